// ===== rtl/mkphd_pkg.sv =====
package mkphd_pkg;

  // Item kinds carried on in_tuser
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_PEEK  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  // Key event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_HOLD    = 2'd2;
  localparam logic [1:0] EV_RELEASE = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_INV_MASK   = 2'd0;
  localparam logic [1:0] REG_PRESS_THR  = 2'd1;
  localparam logic [1:0] REG_HOLD_THR   = 2'd2;

  // Field widths
  localparam int PIN_W   = 6;
  localparam int MS_W    = 12;
  localparam int KEYI_W  = 3;
  localparam int THR_W   = 14;
  localparam int CNT_W   = 16;
  localparam int MAX_KEYS = 8;

  // Register reset values
  localparam logic [PIN_W-1:0] INV_MASK_RST  = 6'd51;
  localparam logic [THR_W-1:0] PRESS_THR_RST = 14'd29;
  localparam logic [THR_W-1:0] HOLD_THR_RST  = 14'd329;

  typedef logic [1:0]              event_t;
  typedef logic signed [CNT_W-1:0] count_t;

endpackage

// ===== rtl/multi_key_press_hold_debouncer.sv =====
// A result is registered and presented in the cycle after its input transaction is accepted.
// Throughput: one item per cycle when out_tready is high; all keys update in parallel in
// that cycle, and the output register lets a new item in as the previous result is taken.
// Reset (rst_n low, synchronous): events none, counters and changed flags zero,
// registers back to inverted_mask 51, press_threshold 29, hold_threshold 329.
module multi_key_press_hold_debouncer #(
  parameter int NUM_KEYS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // elapsed_ms[11:0], pin_levels[17:12], key_index[20:18]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // any_changed[0], key_event[2:1], key_changed[3]
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mkphd_pkg::*;

  localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  // configuration registers
  logic [PIN_W-1:0] inv_mask_r;
  logic [THR_W-1:0] press_thr_r;
  logic [THR_W-1:0] hold_thr_r;

  // per-key state
  event_t ev_r   [NUM_KEYS];
  event_t ev_nxt [NUM_KEYS];
  count_t cnt_r  [NUM_KEYS];
  count_t cnt_nxt[NUM_KEYS];
  logic [NUM_KEYS-1:0] chg_r, chg_nxt;

  // output register
  logic       out_valid_r;
  logic [3:0] out_data_r, out_data_nxt;

  // input fields
  logic [1:0]        kind;
  logic [MS_W-1:0]   elapsed;
  logic [PIN_W-1:0]  pins;
  logic [KEYI_W-1:0] key;
  logic              in_fire;
  logic              key_ok;
  logic [KEY_W-1:0]  kidx;
  logic              cfg_wr;

  assign kind    = in_tuser;
  assign elapsed = in_tdata[11:0];
  assign pins    = in_tdata[17:12];
  assign key     = in_tdata[20:18];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign key_ok    = {1'b0, key} < 4'(NUM_KEYS);
  assign kidx      = KEY_W'(key);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_data_r};

  // Saturate a 17-bit signed value to the counter range
  function automatic count_t sat16(input logic signed [CNT_W:0] v);
    if (v > 17'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -17'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = count_t'(v);
    end
  endfunction

  // Per-key update and result selection
  always_comb begin
    logic [MAX_KEYS-1:0]   act;
    logic signed [CNT_W:0] c17;
    logic signed [CNT_W:0] d17;
    logic signed [CNT_W:0] pt17;
    logic signed [CNT_W:0] ht17;
    count_t                cnew;
    logic                  any;
    event_t                rd_ev;
    logic                  rd_chg;

    act   = {2'b00, pins ^ inv_mask_r};
    d17   = signed'({5'd0, elapsed});
    pt17  = signed'({3'd0, press_thr_r});
    ht17  = signed'({3'd0, hold_thr_r});
    any   = 1'b0;
    rd_ev = EV_NONE;
    rd_chg = 1'b0;
    c17   = '0;
    cnew  = '0;

    for (int k = 0; k < NUM_KEYS; k++) begin
      ev_nxt[k]  = ev_r[k];
      cnt_nxt[k] = cnt_r[k];
      chg_nxt[k] = chg_r[k];
    end

    if (key_ok) begin
      rd_ev  = ev_r[kidx];
      rd_chg = chg_r[kidx];
    end

    if (in_fire) begin
      case (kind)
        KIND_TICK: begin
          if (elapsed != '0) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
              c17 = {cnt_r[k][CNT_W-1], cnt_r[k]};
              if (act[k]) begin
                if (ev_r[k] == EV_NONE || ev_r[k] == EV_RELEASE) begin
                  cnt_nxt[k] = count_t'(pt17);
                  ev_nxt[k]  = EV_PRESS;
                end else if (ev_r[k] == EV_PRESS) begin
                  cnew       = sat16(c17 + d17);
                  cnt_nxt[k] = cnew;
                  if (signed'({cnew[CNT_W-1], cnew}) > ht17) begin
                    ev_nxt[k] = EV_HOLD;
                  end
                end
              end else if (ev_r[k] == EV_PRESS || ev_r[k] == EV_HOLD) begin
                if (c17 > pt17) begin
                  cnt_nxt[k] = count_t'(pt17);
                end else begin
                  cnew       = sat16(c17 - d17);
                  cnt_nxt[k] = cnew;
                  if (cnew[CNT_W-1]) begin
                    ev_nxt[k] = (ev_r[k] == EV_PRESS) ? EV_NONE : EV_RELEASE;
                  end
                end
              end
              if (ev_nxt[k] != ev_r[k]) begin
                chg_nxt[k] = 1'b1;
                any        = 1'b1;
              end
            end
          end
        end
        KIND_READ: begin
          if (key_ok) begin
            if (ev_r[kidx] == EV_RELEASE) begin
              ev_nxt[kidx] = EV_NONE;
            end
            chg_nxt[kidx] = 1'b0;
          end
        end
        KIND_PEEK: begin
        end
        default: begin
          chg_nxt = '0;
        end
      endcase
    end

    // result fields: any_changed, key_event, key_changed
    case (kind)
      KIND_TICK: out_data_nxt = {1'b0, EV_NONE, any};
      KIND_READ: out_data_nxt = {rd_chg, rd_ev, 1'b0};
      KIND_PEEK: out_data_nxt = {1'b0, rd_ev, 1'b0};
      default:   out_data_nxt = 4'd0;
    endcase
  end

  // State and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        ev_r[k]  <= EV_NONE;
        cnt_r[k] <= '0;
      end
      chg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        ev_r[k]  <= ev_nxt[k];
        cnt_r[k] <= cnt_nxt[k];
      end
      chg_r <= chg_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_mask_r  <= INV_MASK_RST;
      press_thr_r <= PRESS_THR_RST;
      hold_thr_r  <= HOLD_THR_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_INV_MASK:  inv_mask_r  <= cfg_pwdata[PIN_W-1:0];
        REG_PRESS_THR: press_thr_r <= cfg_pwdata[THR_W-1:0];
        REG_HOLD_THR:  hold_thr_r  <= cfg_pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_INV_MASK:  cfg_prdata = {26'd0, inv_mask_r};
      REG_PRESS_THR: cfg_prdata = {18'd0, press_thr_r};
      REG_HOLD_THR:  cfg_prdata = {18'd0, hold_thr_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mkphd_pkg::*;

  localparam int NUM_KEYS   = 6;
  localparam int IDLE_LIMIT = 3000;
  localparam int STALL_LEN  = 250;

  // result fields, highest bit first as on out_tdata
  typedef struct packed {
    logic   key_changed;
    event_t key_event;
    logic   any_changed;
  } report_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // elapsed_ms[11:0], pin_levels[17:12], key_index[20:18]
  logic [1:0]  in_tuser;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // any_changed[0], key_event[2:1], key_changed[3]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  multi_key_press_hold_debouncer #(.NUM_KEYS(NUM_KEYS)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predictor copy of registers and per-key state
  logic [PIN_W-1:0] inv_mask;
  int               press_thr;
  int               hold_thr;
  event_t           key_ev  [MAX_KEYS];
  int               key_cnt [MAX_KEYS];
  logic             key_chg [MAX_KEYS];

  report_t expected_reports[$];
  int      errors;
  int      idle_cycles;
  bit      quiet;      // no idling on either side
  bit      stall_req;  // receiver holds off for a long stretch

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_count(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // advance the predictor by one input transaction
  function automatic report_t debounce_step(logic [1:0] kind, logic [MS_W-1:0] dt,
                                            logic [PIN_W-1:0] pins, logic [KEYI_W-1:0] key);
    report_t r;
    event_t  prev;
    logic    act;
    r = '0;
    case (kind)
      KIND_TICK: begin
        if (dt != '0) begin
          for (int k = 0; k < NUM_KEYS; k++) begin
            prev = key_ev[k];
            act  = pins[k] ^ inv_mask[k];
            if (act) begin
              if (prev == EV_NONE || prev == EV_RELEASE) begin
                key_cnt[k] = clamp_count(press_thr);
                key_ev[k]  = EV_PRESS;
              end else if (prev == EV_PRESS) begin
                key_cnt[k] = clamp_count(key_cnt[k] + int'(dt));
                if (key_cnt[k] > hold_thr) key_ev[k] = EV_HOLD;
              end
            end else if (prev == EV_PRESS || prev == EV_HOLD) begin
              if (key_cnt[k] > press_thr) begin
                key_cnt[k] = clamp_count(press_thr);
              end else begin
                key_cnt[k] = clamp_count(key_cnt[k] - int'(dt));
                if (key_cnt[k] < 0) key_ev[k] = (prev == EV_PRESS) ? EV_NONE : EV_RELEASE;
              end
            end
            if (prev != key_ev[k]) begin
              key_chg[k]    = 1'b1;
              r.any_changed = 1'b1;
            end
          end
        end
      end
      KIND_READ: begin
        if (key < NUM_KEYS) begin
          r.key_event   = key_ev[key];
          r.key_changed = key_chg[key];
          if (key_ev[key] == EV_RELEASE) key_ev[key] = EV_NONE;
          key_chg[key] = 1'b0;
        end
      end
      KIND_PEEK: begin
        if (key < NUM_KEYS) r.key_event = key_ev[key];
      end
      default: begin
        for (int k = 0; k < NUM_KEYS; k++) key_chg[k] = 1'b0;
      end
    endcase
    return r;
  endfunction

  // result check, then prediction for each accepted input transaction
  always @(posedge clk) begin
    report_t seen, want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata[3:0];
      if (expected_reports.size() == 0) begin
        $error("result transaction with nothing expected: %h", out_tdata);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        if (seen.any_changed !== want.any_changed) begin
          $error("any_changed: expected %0d, actual %0d", want.any_changed, seen.any_changed);
          errors++;
        end
        if (seen.key_event !== want.key_event) begin
          $error("key_event: expected %0d, actual %0d", want.key_event, seen.key_event);
          errors++;
        end
        if (seen.key_changed !== want.key_changed) begin
          $error("key_changed: expected %0d, actual %0d", want.key_changed, seen.key_changed);
          errors++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready)
      expected_reports.push_back(debounce_step(in_tuser, in_tdata[11:0], in_tdata[17:12],
                                               in_tdata[20:18]));
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || cfg_psel || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (stall_req) begin
        out_tready <= 1'b0;
        repeat (STALL_LEN) @(posedge clk);
        stall_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // one input transaction; tvalid stays high on return
  task automatic send_item(logic [1:0] kind, logic [MS_W-1:0] dt, logic [PIN_W-1:0] pins,
                           logic [KEYI_W-1:0] key);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tdata  <= {3'b000, key, pins, dt};
    in_tuser  <= kind;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // register write while the block is idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
    repeat (2) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_INV_MASK:  inv_mask  = value[PIN_W-1:0];
      REG_PRESS_THR: press_thr = int'(value[THR_W-1:0]);
      REG_HOLD_THR:  hold_thr  = int'(value[THR_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic set_config(logic [PIN_W-1:0] mask, int pt, int ht);
    write_reg(REG_INV_MASK, (32'($urandom) << PIN_W) | 32'(mask));
    write_reg(REG_PRESS_THR, (32'($urandom) << THR_W) | 32'(pt));
    write_reg(REG_HOLD_THR, (32'($urandom) << THR_W) | 32'(ht));
  endtask

  // well-formed key activity with occasional bounce, plus reads, peeks and clears
  task automatic run_traffic(int count);
    logic [PIN_W-1:0]  held, pins;
    logic [MS_W-1:0]   dt;
    logic [KEYI_W-1:0] key;
    logic [1:0]        kind;
    int                pick;
    held = PIN_W'($urandom_range(0, 63));
    repeat (count) begin
      pick = $urandom_range(0, 99);
      dt   = MS_W'($urandom_range(0, 4095));
      pins = PIN_W'($urandom_range(0, 63));
      key  = ($urandom_range(0, 5) == 0) ? KEYI_W'($urandom_range(6, 7))
                                         : KEYI_W'($urandom_range(0, 5));
      if (pick < 68) begin
        kind = KIND_TICK;
        if ($urandom_range(0, 7) == 0) begin
          pick = $urandom_range(0, NUM_KEYS - 1);
          held[pick] = ~held[pick];
        end
        if ($urandom_range(0, 9) != 0) pins = held;
        case ($urandom_range(0, 19))
          0:       dt = '0;
          1:       ;  // keep the full-range value
          default: dt = MS_W'($urandom_range(1, 40));
        endcase
      end else if (pick < 82) begin
        kind = KIND_READ;
      end else if (pick < 94) begin
        kind = KIND_PEEK;
      end else begin
        kind = KIND_CLEAR;
      end
      send_item(kind, dt, pins, key);
    end
  endtask

  // keys 0 and 5 start out as none with no changed flag; key 7 is out of range
  task automatic test_reset_state();
    send_item(KIND_PEEK, MS_W'($urandom), PIN_W'($urandom), 3'd0);
    send_item(KIND_READ, MS_W'($urandom), PIN_W'($urandom), 3'd7);
    send_item(KIND_READ, MS_W'($urandom), PIN_W'($urandom), 3'd5);
  endtask

  // full press / hold / release cycle under the reset thresholds
  task automatic test_press_hold_release();
    send_item(KIND_TICK, 12'd0, 6'd12, 3'd0);     // zero elapsed time: no effect
    send_item(KIND_TICK, 12'd1, 6'd12, 3'd0);     // all keys active -> press
    send_item(KIND_READ, 12'd0, 6'd0, 3'd0);
    send_item(KIND_TICK, 12'd4095, 6'd12, 3'd1);  // past hold threshold
    send_item(KIND_PEEK, 12'd0, 6'd0, 3'd5);
    send_item(KIND_TICK, 12'd1, 6'd51, 3'd0);     // inactive: counter cut back
    send_item(KIND_TICK, 12'd4095, 6'd51, 3'd0);  // counter negative -> release
    send_item(KIND_READ, 12'd0, 6'd0, 3'd2);      // release, then none
    send_item(KIND_READ, 12'd0, 6'd0, 3'd2);
    send_item(KIND_PEEK, 12'd0, 6'd0, 3'd3);
    send_item(KIND_CLEAR, 12'hFFF, 6'h3F, 3'd7);
    send_item(KIND_READ, 12'd0, 6'd0, 3'd3);
    send_item(KIND_TICK, 12'd4095, 6'd63, 3'd0);  // keys 2 and 3 press again
    send_item(KIND_TICK, 12'd4095, 6'd0, 3'd0);   // press dropped straight to none
    send_item(KIND_PEEK, 12'd0, 6'd0, 3'd2);
    send_item(KIND_READ, 12'd0, 6'd0, 3'd6);      // key out of range
    send_item(KIND_PEEK, 12'd0, 6'd0, 3'd6);
  endtask

  // thresholds and mask at both ends of their range
  task automatic test_threshold_extremes();
    set_config(6'd0, 0, 0);
    run_traffic(40);
    set_config(6'd63, 16383, 16383);
    run_traffic(40);
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    stall_req = 1'b1;
    run_traffic(20);
  endtask

  task automatic test_random_traffic();
    repeat (4) begin
      set_config(PIN_W'($urandom_range(0, 63)), $urandom_range(0, 80),
                 $urandom_range(0, 500));
      run_traffic(60);
    end
    set_config(INV_MASK_RST, PRESS_THR_RST, HOLD_THR_RST);
    quiet = 1'b1;
    run_traffic(60);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = KIND_TICK;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    errors      = 0;
    idle_cycles = 0;
    quiet       = 1'b0;
    stall_req   = 1'b0;
    inv_mask    = INV_MASK_RST;
    press_thr   = int'(PRESS_THR_RST);
    hold_thr    = int'(HOLD_THR_RST);
    for (int k = 0; k < MAX_KEYS; k++) begin
      key_ev[k]  = EV_NONE;
      key_cnt[k] = 0;
      key_chg[k] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_press_hold_release();
    test_backpressure();
    test_threshold_extremes();
    test_random_traffic();

    // drain outstanding results
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
    repeat (4) @(posedge clk);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mkphd_pkg.sv
rtl/multi_key_press_hold_debouncer.sv
verif/tb_top.sv
